@@ sv/mpcc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mpcc_pkg;

  localparam logic [2:0] OP_UPDATE     = 3'd0;
  localparam logic [2:0] OP_SET_MODE   = 3'd1;
  localparam logic [2:0] OP_SET_TARGET = 3'd2;
  localparam logic [2:0] OP_SET_MANUAL = 3'd3;
  localparam logic [2:0] OP_SET_ENABLE = 3'd4;

  localparam logic [2:0] MODE_OFF        = 3'd0;
  localparam logic [2:0] MODE_OPEN       = 3'd1;
  localparam logic [2:0] MODE_HOLD       = 3'd2;
  localparam logic [2:0] MODE_CLOSE      = 3'd3;
  localparam logic [2:0] MODE_OPEN_SLOW  = 3'd4;
  localparam logic [2:0] MODE_CLOSE_SLOW = 3'd5;
  localparam logic [2:0] MODE_PCV        = 3'd6;
  localparam logic [2:0] MODE_MANUAL     = 3'd7;

  localparam logic [2:0] REG_CURRENTS_A   = 3'd0;
  localparam logic [2:0] REG_CURRENTS_B   = 3'd1;
  localparam logic [2:0] REG_PROP_GAIN    = 3'd2;
  localparam logic [2:0] REG_INTEG_GAIN   = 3'd3;
  localparam logic [2:0] REG_INTEG_LIMIT  = 3'd4;
  localparam logic [2:0] REG_DUTY_FLOOR   = 3'd5;
  localparam logic [2:0] REG_DUTY_CEILING = 3'd6;
  localparam logic [2:0] REG_SYSTEM_ON    = 3'd7;

  localparam logic signed [26:0] SEED_Q8 = 27'sd397;
  localparam logic [3:0]  RAMP_MA_PER_MS = 4'd6;
  localparam logic signed [13:0] STEP_LIMIT_MA = 14'sd30;
  localparam logic [15:0] DT_MAX_MS  = 16'd100;
  localparam logic [15:0] TARGET_MAX = 16'd4095;
  // ceil(2^40 / 125); exact floor quotient for any 32-bit dividend
  localparam logic [33:0] RECIP_125_Q40 = 34'd8796093023;

  typedef struct packed {
    logic [35:0] currents_a;
    logic [35:0] currents_b;
    logic [15:0] prop_gain;
    logic [15:0] integ_gain;
    logic [15:0] integral_limit;
    logic [15:0] duty_floor;
    logic [15:0] duty_ceiling;
    logic        system_on;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [11:0] target;
    logic [15:0] duty;
    logic [23:0] integral;
    logic [11:0] ramp;
    logic [11:0] prev;
    logic [3:0]  settle;
    logic        enabled;
  } ent_t;

endpackage
`default_nettype wire

@@ sv/mpcc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface mpcc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [2:0]  channel;
  logic [11:0] coil_ma;
  logic [15:0] elapsed_ms;
  logic [2:0]  mode_code;
  logic [15:0] value;

  modport source (output valid, operation, channel, coil_ma, elapsed_ms, mode_code,
                  value, input ready);
  modport sink (input valid, operation, channel, coil_ma, elapsed_ms, mode_code,
                value, output ready);
endinterface

interface mpcc_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         channel_out;
  logic [15:0]        duty;
  logic signed [12:0] error_ma;
  logic               bypassed;

  modport source (output valid, channel_out, duty, error_ma, bypassed, input ready);
  modport sink (input valid, channel_out, duty, error_ma, bypassed, output ready);
endinterface
`default_nettype wire

@@ sv/mpcc_apb_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mpcc_apb_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [5:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output mpcc_pkg::cfg_t    cfg,
  output logic              sys_off
);
  import mpcc_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[5:3];
  assign wr     = psel && penable && pwrite;
  assign sys_off = wr && (idx == REG_SYSTEM_ON) && !pwdata[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.currents_a     <= '0;
      cfg.currents_b     <= '0;
      cfg.prop_gain      <= 16'd128;
      cfg.integ_gain     <= 16'd1536;
      cfg.integral_limit <= 16'hFFFF;
      cfg.duty_floor     <= '0;
      cfg.duty_ceiling   <= 16'hFFFF;
      cfg.system_on      <= 1'b1;
    end else if (wr) begin
      case (idx)
        REG_CURRENTS_A:   cfg.currents_a     <= pwdata[35:0];
        REG_CURRENTS_B:   cfg.currents_b     <= pwdata[35:0];
        REG_PROP_GAIN:    cfg.prop_gain      <= pwdata[15:0];
        REG_INTEG_GAIN:   cfg.integ_gain     <= pwdata[15:0];
        REG_INTEG_LIMIT:  cfg.integral_limit <= pwdata[15:0];
        REG_DUTY_FLOOR:   cfg.duty_floor     <= pwdata[15:0];
        REG_DUTY_CEILING: cfg.duty_ceiling   <= pwdata[15:0];
        REG_SYSTEM_ON:    cfg.system_on      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CURRENTS_A:   prdata = {28'd0, cfg.currents_a};
      REG_CURRENTS_B:   prdata = {28'd0, cfg.currents_b};
      REG_PROP_GAIN:    prdata = {48'd0, cfg.prop_gain};
      REG_INTEG_GAIN:   prdata = {48'd0, cfg.integ_gain};
      REG_INTEG_LIMIT:  prdata = {48'd0, cfg.integral_limit};
      REG_DUTY_FLOOR:   prdata = {48'd0, cfg.duty_floor};
      REG_DUTY_CEILING: prdata = {48'd0, cfg.duty_ceiling};
      REG_SYSTEM_ON:    prdata = {63'd0, cfg.system_on};
      default:          prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

@@ sv/multichannel_pi_current_controller_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Commands pass through the evaluate and done states; the next transaction is accepted
// once the result is committed. Updates add the multiply chain (gain, dt, two reciprocal
// partial products), the integral clamp and the duty stage, plus the read-modify-write
// of the channel state memory. One transaction is in flight at a time; a held result
// stalls the last state until the output register frees.
// Synchronous active-high reset; channel entries read as their reset values through
// per-entry valid bits, so no clearing pass is needed.
module multichannel_pi_current_controller_core #(
  parameter int CHANNELS       = 8,
  parameter int SETTLE_UPDATES = 15
) (
  input  logic        clk,
  input  logic        rst,
  mpcc_in_if.sink     cmd,
  mpcc_out_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import mpcc_pkg::*;

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [3:0] SETTLE_LOAD = 4'(SETTLE_UPDATES);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_EVAL  = 9'b000000010,
    S_MUL1  = 9'b000000100,
    S_MUL2  = 9'b000001000,
    S_DIVL  = 9'b000010000,
    S_DIVH  = 9'b000100000,
    S_INTEG = 9'b001000000,
    S_DUTY  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  cfg_t   cfg;
  logic   sys_off;
  state_t state;

  mpcc_apb_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg, .sys_off
  );

  ent_t              mem [CHANNELS];
  logic [CHANNELS-1:0] vld;
  logic [CHANNELS-1:0] dz;
  ent_t              rd_ent;
  logic              rd_vld, rd_dz;
  ent_t              cur;
  ent_t              wk;
  ent_t              eval_ent;

  logic [2:0]  op_r, chan_r, mc_r;
  logic [11:0] meas_r;
  logic [15:0] el_r, val_r;
  logic        inr_r;
  logic [CW-1:0] idx_r;
  logic        accept;
  logic [CW-1:0] in_idx;
  logic        in_range;

  logic [15:0]        res_duty, eval_duty;
  logic signed [12:0] res_err;
  logic               res_byp, eval_byp;
  logic               eval_regulate;

  logic [6:0]  dt, dt_q;
  logic [9:0]  step;
  logic [11:0] ramp, ramp_q;
  logic signed [13:0] d1, d2;
  logic signed [26:0] integ_s;
  logic [23:0] integ_c, integ_q, integ_f;
  logic [3:0]  settle_c, settle_q;
  logic signed [12:0] err, err_q;
  logic        skip, skip_q;
  logic [11:0] mag, mag_q;
  logic [27:0] p1;
  logic [31:0] y;
  logic [34:0] p2;
  logic [48:0] pl, ph;
  logic [65:0] qsum;
  logic [25:0] delta;
  logic signed [26:0] integ2;
  logic signed [31:0] o_raw, o_lo, o_hi, o_cl;

  logic               out_valid;
  logic [2:0]         out_chan;
  logic [15:0]        out_duty;
  logic signed [12:0] out_err;
  logic               out_byp;
  logic               commit;

  function automatic logic [23:0] clamp_int(input logic signed [26:0] v, input logic [15:0] lim);
    logic signed [26:0] top;
    top = $signed({3'b000, lim, 8'h00});
    if (v < 0) return '0;
    else if (v > top) return top[23:0];
    else return v[23:0];
  endfunction

  function automatic logic [11:0] mode_current(input logic [2:0] m, input cfg_t c);
    case (m)
      MODE_OPEN:       return c.currents_a[11:0];
      MODE_HOLD:       return c.currents_a[23:12];
      MODE_CLOSE:      return c.currents_a[35:24];
      MODE_OPEN_SLOW:  return c.currents_b[11:0];
      MODE_CLOSE_SLOW: return c.currents_b[23:12];
      MODE_PCV:        return c.currents_b[35:24];
      default:         return '0;
    endcase
  endfunction

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign in_idx    = CW'(cmd.channel);
  assign in_range  = 32'(cmd.channel) < CHANNELS;
  assign commit    = (state == S_DONE) && (!out_valid || rsp.ready);

  // memory read at accept, write back at commit
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_ent <= mem[in_idx];
    end
    if (commit && inr_r) begin
      mem[idx_r] <= wk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      dz  <= '0;
    end else begin
      if (sys_off) begin
        dz <= '1;
      end else if (commit && inr_r) begin
        dz[idx_r] <= 1'b0;
      end
      if (commit && inr_r) begin
        vld[idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= cmd.operation;
      chan_r <= cmd.channel;
      meas_r <= cmd.coil_ma;
      el_r   <= cmd.elapsed_ms;
      mc_r   <= cmd.mode_code;
      val_r  <= cmd.value;
      inr_r  <= in_range;
      idx_r  <= in_idx;
      rd_vld <= vld[in_idx];
      rd_dz  <= dz[in_idx];
    end
  end

  always_comb begin
    if (!rd_vld) begin
      cur = '0;
      cur.enabled = 1'b1;
    end else begin
      cur = rd_ent;
      if (rd_dz) cur.duty = '0;
    end
  end

  // setpoint ramp, integral seeding, error
  always_comb begin
    if (el_r == 16'd0) dt = 7'd1;
    else if (el_r > DT_MAX_MS) dt = DT_MAX_MS[6:0];
    else dt = el_r[6:0];
    step = 10'(RAMP_MA_PER_MS) * 10'(dt);
    d1 = $signed({2'b00, cur.target}) - $signed({2'b00, cur.ramp});
    if (cur.mode == MODE_OPEN || cur.mode == MODE_OPEN_SLOW) begin
      if (d1 <= $signed({4'b0, step}) && -d1 <= $signed({4'b0, step})) ramp = cur.target;
      else if (d1 > 0) ramp = cur.ramp + 12'(step);
      else ramp = cur.ramp - 12'(step);
    end else begin
      ramp = cur.target;
    end
    d2 = $signed({2'b00, ramp}) - $signed({2'b00, cur.prev});
    if (cur.prev == '0) begin
      integ_s  = $signed({15'd0, ramp}) * SEED_Q8;
      settle_c = SETTLE_LOAD;
    end else if (d2 >= STEP_LIMIT_MA || -d2 >= STEP_LIMIT_MA) begin
      integ_s  = $signed({3'b000, cur.integral}) + 27'(d2) * SEED_Q8;
      settle_c = SETTLE_LOAD;
    end else begin
      integ_s  = $signed({3'b000, cur.integral});
      settle_c = cur.settle;
    end
    integ_c = clamp_int(integ_s, cfg.integral_limit);
    err  = $signed({1'b0, ramp}) - $signed({1'b0, meas_r});
    skip = (settle_c != 4'd0) && (err > 0);
    mag  = err < 0 ? 12'(-err) : 12'(err);
  end

  // command handling and update early exits
  always_comb begin
    eval_ent      = cur;
    eval_duty     = cur.duty;
    eval_byp      = 1'b0;
    eval_regulate = 1'b0;
    case (op_r)
      OP_UPDATE: begin
        if (!cfg.system_on || !cur.enabled || (cur.target == '0 &&
            !(cur.mode == MODE_MANUAL && cur.duty != '0))) begin
          eval_ent.duty     = '0;
          eval_ent.integral = '0;
          eval_ent.ramp     = '0;
          eval_ent.prev     = '0;
          eval_ent.settle   = '0;
          eval_duty         = '0;
        end else if (cur.target == '0) begin
          eval_byp = 1'b1;
        end else begin
          eval_regulate = 1'b1;
        end
      end
      OP_SET_MODE: begin
        eval_ent.mode = mc_r;
        if (mc_r == MODE_OFF) begin
          eval_ent.target   = '0;
          eval_ent.integral = '0;
          eval_ent.ramp     = '0;
          eval_ent.prev     = '0;
          eval_ent.settle   = '0;
        end else if (mc_r == MODE_MANUAL) begin
          eval_ent.target = '0;
        end else begin
          eval_ent.target = mode_current(mc_r, cfg);
        end
        eval_ent.duty = val_r;
        eval_duty     = val_r;
      end
      OP_SET_TARGET: begin
        eval_ent.target = val_r > TARGET_MAX ? TARGET_MAX[11:0] : val_r[11:0];
        if (val_r == '0) begin
          eval_ent.integral = '0;
          eval_ent.ramp     = '0;
        end
      end
      OP_SET_MANUAL: begin
        eval_ent.mode   = MODE_MANUAL;
        eval_ent.duty   = val_r;
        eval_ent.target = '0;
        eval_duty       = val_r;
      end
      OP_SET_ENABLE: begin
        eval_ent.enabled = (val_r != '0);
        if (val_r == '0) begin
          eval_ent.duty = '0;
          eval_duty     = '0;
        end
      end
      default: ;
    endcase
  end

  assign p2    = 35'(p1) * 35'(dt_q);
  assign qsum  = {ph, 17'd0} + 66'(pl);
  assign delta = qsum[65:40];
  assign integ2 = skip_q ? $signed({3'b000, integ_q}) :
                  (err_q < 0 ? $signed({3'b000, integ_q}) - $signed({1'b0, delta})
                             : $signed({3'b000, integ_q}) + $signed({1'b0, delta}));
  assign o_raw = $signed({16'd0, cfg.prop_gain}) * 32'(err_q) + $signed({8'd0, integ_f});
  assign o_lo  = $signed({8'd0, cfg.duty_floor, 8'h00});
  assign o_hi  = $signed({8'd0, cfg.duty_ceiling, 8'h00});

  always_comb begin
    o_cl = o_raw;
    if (o_cl < o_lo) o_cl = o_lo;
    if (o_cl > o_hi) o_cl = o_hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:  if (accept) state <= S_EVAL;
        S_EVAL:  state <= (inr_r && eval_regulate) ? S_MUL1 : S_DONE;
        S_MUL1:  state <= S_MUL2;
        S_MUL2:  state <= S_DIVL;
        S_DIVL:  state <= S_DIVH;
        S_DIVH:  state <= S_INTEG;
        S_INTEG: state <= S_DUTY;
        S_DUTY:  state <= S_DONE;
        S_DONE:  if (commit) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_EVAL: begin
        wk       <= eval_ent;
        res_duty <= inr_r ? eval_duty : 16'd0;
        res_err  <= '0;
        res_byp  <= inr_r && eval_byp;
        ramp_q   <= ramp;
        integ_q  <= integ_c;
        settle_q <= (settle_c != 4'd0) ? settle_c - 4'd1 : settle_c;
        err_q    <= err;
        skip_q   <= skip;
        mag_q    <= mag;
        dt_q     <= dt;
      end
      S_MUL1: p1 <= 28'(cfg.integ_gain) * 28'(mag_q);
      S_MUL2: y  <= p2[34:3];
      S_DIVL: pl <= 49'(y) * 49'(RECIP_125_Q40[16:0]);
      S_DIVH: ph <= 49'(y) * 49'(RECIP_125_Q40[33:17]);
      S_INTEG: integ_f <= clamp_int(integ2, cfg.integral_limit);
      S_DUTY: begin
        wk.integral <= integ_f;
        wk.ramp     <= ramp_q;
        wk.prev     <= ramp_q;
        wk.settle   <= settle_q;
        wk.duty     <= o_cl[23:8];
        res_duty    <= o_cl[23:8];
        res_err     <= err_q;
      end
      default: ;
    endcase
  end

  // output register, parts the result from the next transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_chan <= chan_r;
      out_duty <= res_duty;
      out_err  <= res_err;
      out_byp  <= res_byp;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.channel_out = out_chan;
  assign rsp.duty        = out_duty;
  assign rsp.error_ma    = out_err;
  assign rsp.bypassed    = out_byp;

endmodule
`default_nettype wire

@@ dv/mpcc_checker.sv @@
`timescale 1ns / 1ps
module mpcc_checker (
  input  logic        clk,
  input  logic        rst,
  mpcc_in_if          cmd,
  mpcc_out_if         rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output int          fails,
  output int          pending
);
  import mpcc_pkg::*;

  localparam int NCH = 8;

  typedef struct packed {
    logic [2:0]         ch;
    logic [15:0]        duty;
    logic signed [12:0] err;
    logic               byp;
  } duty_result_t;

  duty_result_t duty_q[$];

  cfg_t        cfg;
  logic [2:0]  mode_r   [NCH];
  logic [11:0] target_r [NCH];
  logic [15:0] duty_r   [NCH];
  longint      integ_r  [NCH];
  longint      ramp_r   [NCH];
  longint      prev_r   [NCH];
  int          settle_r [NCH];
  logic        enable_r [NCH];

  function automatic logic [11:0] mode_ma(logic [2:0] m);
    case (m)
      MODE_OPEN:       return cfg.currents_a[11:0];
      MODE_HOLD:       return cfg.currents_a[23:12];
      MODE_CLOSE:      return cfg.currents_a[35:24];
      MODE_OPEN_SLOW:  return cfg.currents_b[11:0];
      MODE_CLOSE_SLOW: return cfg.currents_b[23:12];
      MODE_PCV:        return cfg.currents_b[35:24];
      default:         return 12'd0;
    endcase
  endfunction

  function automatic void clear_loop(int c);
    integ_r[c]  = 0;
    ramp_r[c]   = 0;
    prev_r[c]   = 0;
    settle_r[c] = 0;
  endfunction

  function automatic longint clip_integ(longint v);
    longint top;
    top = longint'(cfg.integral_limit) * 256;
    if (v < 0) v = 0;
    if (v > top) v = top;
    return v;
  endfunction

  function automatic duty_result_t regulate(int c, logic [11:0] meas, logic [15:0] el);
    duty_result_t r;
    longint dt, sp, d, stp, e, mag, dl, o, lo, hi;
    bit settling;
    r = '0;
    r.ch = c[2:0];
    if (!cfg.system_on || !enable_r[c]) begin
      duty_r[c] = 0;
      clear_loop(c);
      return r;
    end
    dt = longint'(el);
    if (dt < 1) dt = 1;
    if (dt > 100) dt = 100;
    if (mode_r[c] == MODE_MANUAL && duty_r[c] != 0 && target_r[c] == 0) begin
      r.byp = 1'b1;
      r.duty = duty_r[c];
      return r;
    end
    if (target_r[c] == 0) begin
      duty_r[c] = 0;
      clear_loop(c);
      return r;
    end
    sp = ramp_r[c];
    if (mode_r[c] == MODE_OPEN || mode_r[c] == MODE_OPEN_SLOW) begin
      d = longint'(target_r[c]) - sp;
      stp = 6 * dt;
      if (d <= stp && -d <= stp) sp = longint'(target_r[c]);
      else if (d > 0) sp += stp;
      else sp -= stp;
    end else begin
      sp = longint'(target_r[c]);
    end
    d = sp - prev_r[c];
    if (prev_r[c] <= 0) begin
      integ_r[c] = sp * 397;
      settle_r[c] = 15;
    end else if (d >= 30 || -d >= 30) begin
      integ_r[c] += d * 397;
      settle_r[c] = 15;
    end
    integ_r[c] = clip_integ(integ_r[c]);
    ramp_r[c] = sp;
    prev_r[c] = sp;
    e = sp - longint'(meas);
    r.err = e[12:0];
    settling = settle_r[c] > 0;
    if (settling) settle_r[c]--;
    if (!(settling && e > 0)) begin
      mag = e < 0 ? -e : e;
      dl = (longint'(cfg.integ_gain) * mag * dt) / 1000;
      integ_r[c] += e < 0 ? -dl : dl;
    end
    integ_r[c] = clip_integ(integ_r[c]);
    o = longint'(cfg.prop_gain) * e + integ_r[c];
    lo = longint'(cfg.duty_floor) * 256;
    hi = longint'(cfg.duty_ceiling) * 256;
    if (o < lo) o = lo;
    if (o > hi) o = hi;
    o = o / 256;
    duty_r[c] = o[15:0];
    r.duty = duty_r[c];
    return r;
  endfunction

  function automatic duty_result_t next_duty(logic [2:0] op, logic [2:0] ch,
                                             logic [11:0] meas, logic [15:0] el,
                                             logic [2:0] mc, logic [15:0] val);
    duty_result_t r;
    int c;
    c = int'(ch);
    r = '0;
    r.ch = ch;
    case (op)
      OP_UPDATE: r = regulate(c, meas, el);
      OP_SET_MODE: begin
        mode_r[c] = mc;
        if (mc == MODE_OFF) begin
          target_r[c] = 0;
          clear_loop(c);
        end else if (mc == MODE_MANUAL) target_r[c] = 0;
        else target_r[c] = mode_ma(mc);
        duty_r[c] = val;
        r.duty = val;
      end
      OP_SET_TARGET: begin
        target_r[c] = val > TARGET_MAX ? 12'hfff : val[11:0];
        if (val == 0) begin
          integ_r[c] = 0;
          ramp_r[c] = 0;
        end
        r.duty = duty_r[c];
      end
      OP_SET_MANUAL: begin
        mode_r[c] = MODE_MANUAL;
        duty_r[c] = val;
        target_r[c] = 0;
        r.duty = val;
      end
      OP_SET_ENABLE: begin
        enable_r[c] = val != 0;
        if (val == 0) duty_r[c] = 0;
        r.duty = duty_r[c];
      end
      default: r.duty = duty_r[c];
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    duty_result_t got, want;
    if (rst) begin
      cfg.currents_a     = '0;
      cfg.currents_b     = '0;
      cfg.prop_gain      = 16'd128;
      cfg.integ_gain     = 16'd1536;
      cfg.integral_limit = 16'hffff;
      cfg.duty_floor     = '0;
      cfg.duty_ceiling   = 16'hffff;
      cfg.system_on      = 1'b1;
      for (int i = 0; i < NCH; i++) begin
        mode_r[i] = MODE_OFF;
        target_r[i] = 0;
        duty_r[i] = 0;
        enable_r[i] = 1'b1;
        clear_loop(i);
      end
      duty_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_CURRENTS_A:   cfg.currents_a = pwdata[35:0];
          REG_CURRENTS_B:   cfg.currents_b = pwdata[35:0];
          REG_PROP_GAIN:    cfg.prop_gain = pwdata[15:0];
          REG_INTEG_GAIN:   cfg.integ_gain = pwdata[15:0];
          REG_INTEG_LIMIT:  cfg.integral_limit = pwdata[15:0];
          REG_DUTY_FLOOR:   cfg.duty_floor = pwdata[15:0];
          REG_DUTY_CEILING: cfg.duty_ceiling = pwdata[15:0];
          REG_SYSTEM_ON: begin
            cfg.system_on = pwdata[0];
            if (!pwdata[0]) for (int i = 0; i < NCH; i++) duty_r[i] = 0;
          end
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready)
        duty_q.push_back(next_duty(cmd.operation, cmd.channel, cmd.coil_ma,
                                   cmd.elapsed_ms, cmd.mode_code, cmd.value));
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.channel_out, rsp.duty, rsp.error_ma, rsp.bypassed};
        if (duty_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected transaction: %p", got);
        end else begin
          want = duty_q.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10) $display("mismatch: expected %p, actual %p", want, got);
          end
        end
      end
    end
    pending = duty_q.size();
  end

  initial begin
    fails = 0;
    pending = 0;
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import mpcc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  int          fails, pending;
  int          cycles = 0;
  int          sent = 0;
  bit          hold_req = 1'b0;
  bit          burst = 1'b0;
  logic [35:0] cur_a = '0, cur_b = '0;

  mpcc_in_if  cmd ();
  mpcc_out_if rsp ();

  multichannel_pi_current_controller_core uut (
    .clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  mpcc_checker chk (
    .clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp), .psel(psel), .penable(penable),
    .pwrite(pwrite), .pready(pready), .paddr(paddr), .pwdata(pwdata),
    .fails(fails), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    cmd.valid = 1'b0;
    cmd.operation = OP_UPDATE;
    cmd.channel = '0;
    cmd.coil_ma = '0;
    cmd.elapsed_ms = '0;
    cmd.mode_code = MODE_OFF;
    cmd.value = '0;
    rsp.ready = 1'b1;
  end

  // response side: random stalls, long hold-off on request
  initial begin
    bit hit;
    int g;
    @(negedge rst);
    forever begin
      g = burst ? 0 : int'($urandom_range(0, 3));
      if (hold_req) begin
        @(posedge clk);
        rsp.ready <= 1'b0;
        repeat (300) @(posedge clk);
        rsp.ready <= 1'b1;
        hold_req = 1'b0;
      end else if (g > 0) begin
        @(posedge clk);
        rsp.ready <= 1'b0;
        repeat (g) @(posedge clk);
        rsp.ready <= 1'b1;
      end
      do begin
        @(negedge clk);
        hit = rsp.valid && rsp.ready;
        @(posedge clk);
      end while (!hit);
    end
  end

  task automatic send(logic [2:0] op, logic [2:0] ch, logic [11:0] meas,
                      logic [15:0] el, logic [2:0] mc, logic [15:0] val);
    bit hit;
    int g;
    g = burst ? 0 : int'($urandom_range(0, 3));
    if (g > 0) begin
      cmd.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.operation <= op;
    cmd.channel <= ch;
    cmd.coil_ma <= meas;
    cmd.elapsed_ms <= el;
    cmd.mode_code <= mc;
    cmd.value <= val;
    do begin
      @(negedge clk);
      hit = cmd.ready;
      @(posedge clk);
    end while (!hit);
    sent++;
  endtask

  // wait for all results, then past the update latency
  task automatic drain();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [63:0] data);
    if (idx == REG_CURRENTS_A) cur_a = data[35:0];
    if (idx == REG_CURRENTS_B) cur_b = data[35:0];
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 3'b000};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [11:0] near_ma(logic [2:0] mc);
    logic [11:0] t;
    int v;
    case (mc)
      MODE_OPEN:       t = cur_a[11:0];
      MODE_HOLD:       t = cur_a[23:12];
      MODE_CLOSE:      t = cur_a[35:24];
      MODE_OPEN_SLOW:  t = cur_b[11:0];
      MODE_CLOSE_SLOW: t = cur_b[23:12];
      default:         t = cur_b[35:24];
    endcase
    v = int'(t) + int'($urandom_range(0, 160)) - 80;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  task automatic random_sequence();
    logic [2:0] ch, mc;
    int n, pick;
    ch = 3'($urandom_range(0, 7));
    pick = int'($urandom_range(0, 99));
    if (pick < 60) begin
      mc = 3'($urandom_range(1, 6));
      send(OP_SET_MODE, ch, 12'($urandom), 16'($urandom), mc,
           ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0);
      if ($urandom_range(0, 3) == 0)
        send(OP_SET_TARGET, ch, 12'($urandom), 16'($urandom), 3'($urandom),
             16'($urandom_range(1, 4095)));
      n = int'($urandom_range(3, 12));
      repeat (n)
        send(OP_UPDATE, ch, ($urandom_range(0, 4) == 0) ? 12'($urandom) : near_ma(mc),
             ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 25)),
             3'($urandom), 16'($urandom));
    end else if (pick < 72) begin
      send(OP_SET_MANUAL, ch, 12'($urandom), 16'($urandom), 3'($urandom),
           ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom));
      repeat ($urandom_range(1, 3))
        send(OP_UPDATE, ch, 12'($urandom), 16'($urandom), 3'($urandom), 16'($urandom));
    end else if (pick < 80) begin
      send(OP_SET_ENABLE, ch, 12'($urandom), 16'($urandom), 3'($urandom),
           ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom));
    end else begin
      // noise: any field, any operation code
      send(3'($urandom), ch, 12'($urandom), 16'($urandom), 3'($urandom), 16'($urandom));
    end
  endtask

  task automatic set_all(logic [35:0] a, logic [35:0] b, logic [15:0] kp,
                         logic [15:0] ki, logic [15:0] lim, logic [15:0] lo,
                         logic [15:0] hi);
    reg_write(REG_CURRENTS_A, {28'($urandom), a});
    reg_write(REG_CURRENTS_B, {28'($urandom), b});
    reg_write(REG_PROP_GAIN, {48'($urandom), kp});
    reg_write(REG_INTEG_GAIN, 64'(ki));
    reg_write(REG_INTEG_LIMIT, 64'(lim));
    reg_write(REG_DUTY_FLOOR, 64'(lo));
    reg_write(REG_DUTY_CEILING, 64'(hi));
    reg_write(REG_SYSTEM_ON, 64'd1);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_all({12'd200, 12'd4095, 12'd100}, {12'd0, 12'd60, 12'd1000},
            16'd128, 16'd1536, 16'hffff, 16'd0, 16'hffff);
    send(OP_UPDATE, 3'd0, 12'd0, 16'd10, MODE_OFF, 16'd0);
    send(OP_SET_TARGET, 3'd1, 12'd0, 16'd0, MODE_OFF, 16'hffff);
    send(OP_UPDATE, 3'd1, 12'd0, 16'd0, MODE_OFF, 16'd0);
    send(OP_UPDATE, 3'd1, 12'hfff, 16'hffff, MODE_OFF, 16'd0);
    send(OP_SET_TARGET, 3'd1, 12'd0, 16'd0, MODE_OFF, 16'd100);
    send(OP_UPDATE, 3'd1, 12'd100, 16'd5, MODE_OFF, 16'd0);
    send(OP_SET_MODE, 3'd2, 12'd0, 16'd0, MODE_OPEN, 16'd0);
    send(OP_UPDATE, 3'd2, 12'd20, 16'd5, MODE_OFF, 16'd0);
    send(OP_UPDATE, 3'd2, 12'd90, 16'd100, MODE_OFF, 16'd0);
    send(OP_SET_MODE, 3'd3, 12'd0, 16'd0, MODE_HOLD, 16'd1234);
    send(OP_UPDATE, 3'd3, 12'd4000, 16'd7, MODE_OFF, 16'd0);
    send(OP_SET_TARGET, 3'd3, 12'd0, 16'd0, MODE_OFF, 16'd0);
    send(OP_UPDATE, 3'd3, 12'd0, 16'd7, MODE_OFF, 16'd0);
    send(OP_SET_MANUAL, 3'd4, 12'd0, 16'd0, MODE_OFF, 16'd500);
    send(OP_UPDATE, 3'd4, 12'd33, 16'd3, MODE_OFF, 16'd0);
    send(OP_SET_MANUAL, 3'd4, 12'd0, 16'd0, MODE_OFF, 16'd0);
    send(OP_UPDATE, 3'd4, 12'd33, 16'd3, MODE_OFF, 16'd0);
    send(OP_SET_ENABLE, 3'd5, 12'd0, 16'd0, MODE_OFF, 16'd0);
    send(OP_UPDATE, 3'd5, 12'd0, 16'd3, MODE_OFF, 16'd0);
    send(OP_SET_ENABLE, 3'd5, 12'd0, 16'd0, MODE_OFF, 16'h8000);
    send(OP_SET_MODE, 3'd6, 12'd0, 16'd0, MODE_OPEN_SLOW, 16'd0);
    send(OP_SET_MODE, 3'd7, 12'd0, 16'd0, MODE_CLOSE_SLOW, 16'hffff);
    send(OP_SET_MODE, 3'd6, 12'd0, 16'd0, MODE_PCV, 16'd0);
    send(3'd5, 3'd6, 12'd0, 16'd0, MODE_OFF, 16'd0);
    send(3'd7, 3'd7, 12'd0, 16'd0, MODE_MANUAL, 16'd0);
    send(OP_SET_MODE, 3'd2, 12'd0, 16'd0, MODE_OFF, 16'd0);
    drain();
    reg_write(REG_SYSTEM_ON, 64'd0);
    send(OP_UPDATE, 3'd7, 12'd10, 16'd10, MODE_OFF, 16'd0);
    send(OP_SET_TARGET, 3'd7, 12'd0, 16'd0, MODE_OFF, 16'd0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_all(36'($urandom), 36'($urandom), 16'($urandom_range(0, 600)),
                   16'($urandom_range(0, 8000)), 16'($urandom),
                   16'($urandom_range(0, 200)), 16'($urandom_range(2000, 65535)));
        1: set_all(36'hfff_fff_fff, 36'hfff_fff_fff, 16'hffff, 16'hffff, 16'hffff,
                   16'hffff, 16'hffff);
        2: set_all(36'd0, 36'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        3: set_all(36'($urandom), 36'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom));
        default: set_all({12'd800, 12'd300, 12'd1500}, {12'd2500, 12'd40, 12'd700},
                         16'd128, 16'd1536, 16'd4000, 16'd50, 16'd3000);
      endcase
      burst = (ph == 3);
      if (ph == 1) hold_req = 1'b1;
      while (sent < 60 + 150 * (ph + 1)) random_sequence();
      burst = 1'b0;
      drain();
    end

    // turn the system off mid-run and back on
    reg_write(REG_SYSTEM_ON, 64'd0);
    repeat (10) random_sequence();
    drain();
    reg_write(REG_SYSTEM_ON, 64'd1);
    repeat (20) random_sequence();
    drain();
    repeat (20) @(posedge clk);

    if (fails == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/mpcc_pkg.sv
sv/mpcc_if.sv
sv/mpcc_apb_regs.sv
sv/multichannel_pi_current_controller_core.sv
dv/mpcc_checker.sv
dv/tb.sv
